FILE: sv/bvrm_pkg.sv
// ----------------------------------------------------------------------------
// bvrm_pkg: shared types and constants of the band-pass vibration RMS meter
// Register indexes, fixed field widths and the control word of the serial
// multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package bvrm_pkg;

	localparam int NCH      = 5;
	localparam int FW       = 32;     // filter value width
	localparam int FRAC     = 8;      // filter fraction bits
	localparam int SUM_W    = 2 * FW; // sum of squares width
	localparam int OUT_W    = 18;     // result field width
	localparam int MSW      = 2 * OUT_W; // mean square width
	localparam int CNT_W    = 6;      // serial step counter width
	localparam int CFG_IDX_W = 3;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_COEF_WIDTH   = 16;

	localparam int HP_COEF_RST  = 43608;
	localparam int LP_COEF_RST  = 46884;
	localparam int RMS_COEF_RST = 5958;

	localparam logic [CFG_IDX_W-1:0] REG_HP_COEF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LP_COEF  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RMS_COEF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_AX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_AY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_AZ   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_GY   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_GZ   = 3'd7;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
	} mul_ctl_t;

endpackage

`default_nettype wire

FILE: sv/bvrm_in_if.sv
// ----------------------------------------------------------------------------
// bvrm_in_if: sample set channel
// Valid/ready channel carrying the five raw sensor axes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvrm_in_if #(
	parameter int SW = 16
);
	logic          valid;
	logic          ready;
	logic signed [SW-1:0] accel_x;
	logic signed [SW-1:0] accel_y;
	logic signed [SW-1:0] accel_z;
	logic signed [SW-1:0] gyro_y;
	logic signed [SW-1:0] gyro_z;

	modport source (output valid, accel_x, accel_y, accel_z, gyro_y, gyro_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, gyro_y, gyro_z, output ready);
endinterface

`default_nettype wire

FILE: sv/bvrm_out_if.sv
// ----------------------------------------------------------------------------
// bvrm_out_if: result channel
// Valid/ready channel carrying both magnitudes and both RMS values.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvrm_out_if;
	logic valid;
	logic ready;
	logic [bvrm_pkg::OUT_W-1:0] accel_magnitude;
	logic [bvrm_pkg::OUT_W-1:0] gyro_magnitude;
	logic [bvrm_pkg::OUT_W-1:0] accel_rms;
	logic [bvrm_pkg::OUT_W-1:0] gyro_rms;

	modport source (output valid, accel_magnitude, gyro_magnitude, accel_rms, gyro_rms,
		input ready);
	modport sink   (input valid, accel_magnitude, gyro_magnitude, accel_rms, gyro_rms,
		output ready);
endinterface

`default_nettype wire

FILE: sv/bvrm_mul.sv
// ----------------------------------------------------------------------------
// bvrm_mul: bit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per
// cycle, MSB first. The multiplier arrives left-aligned; nbits bits are used.
// ----------------------------------------------------------------------------
`default_nettype none

module bvrm_mul #(
	parameter int MA = 40,
	parameter int MB = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bvrm_pkg::mul_ctl_t      ctl,
	input  wire logic signed [MA-1:0]    a,
	input  wire logic [MB-1:0]           b,
	output logic signed [MA+MB-1:0]      prod,
	output logic                         done
);
	import bvrm_pkg::*;

	localparam int PW = MA + MB;

	logic signed [PW-1:0] acc_q;
	logic signed [MA-1:0] a_q;
	logic [MB-1:0]        b_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			// shift and add the sign-extended multiplicand on a one bit
			acc_q <= (acc_q <<< 1) + (b_q[MB-1] ? {{MB{a_q[MA-1]}}, a_q} : PW'(0));
			b_q   <= b_q << 1;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/bvrm_sqrt.sv
// ----------------------------------------------------------------------------
// bvrm_sqrt: digit-by-digit integer square root
// Floor root of a W-bit unsigned value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bvrm_sqrt #(
	parameter int W = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [W-1:0]   n,
	output logic [W/2-1:0]      root,
	output logic                done
);
	import bvrm_pkg::*;

	localparam int RW = W / 2;

	logic [W-1:0]     n_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW+3:0] shifted;
	logic [RW+3:0] trial;
	logic          ge;

	assign shifted = {rem_q, n_q[W-1:W-2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= n_q << 2;
			rem_q  <= ge ? (RW+2)'(shifted - trial) : (RW+2)'(shifted);
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/bandpass_vibration_rms_meter.sv
// ----------------------------------------------------------------------------
// bandpass_vibration_rms_meter: band-passed accel/gyro magnitude and RMS
// Offset removal, first-order high-pass and low-pass per axis, vector
// magnitude per sensor group, smoothed mean square and its root.
// ----------------------------------------------------------------------------
//  channel   dir  beat                       handshake
//  samples   in   five raw axes              valid/ready
//  results   out  2 magnitudes, 2 RMS values valid/ready
//  wr_*      in   register index and data    wr_en, no wait
//
//  The time a sample set takes is set by the shared bit-serial multiplier and
//  the bit-serial root unit. One set is worked at a time; the next is taken
//  once the result is parked in the output register. A stalled output holds
//  the block at its last step. Reset clears all filter and mean-square state
//  and loads default coefs.
// ----------------------------------------------------------------------------
`default_nettype none

module bandpass_vibration_rms_meter #(
	parameter int SAMPLE_WIDTH = bvrm_pkg::DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = bvrm_pkg::DEF_COEF_WIDTH,
	parameter int CFGW = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	bvrm_in_if.sink                              samples,
	bvrm_out_if.source                           results,
	input  wire logic                            wr_en,
	input  wire logic [bvrm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFGW-1:0]                 wr_data
);
	import bvrm_pkg::*;

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = COEF_WIDTH;
	localparam int XW  = SW + 1;
	localparam int DW  = XW + 1;
	localparam int VW  = ((FW > DW + FRAC) ? FW : DW + FRAC) + 1;
	localparam int MA  = (VW > MSW + 1) ? VW : MSW + 1;
	localparam int MB  = (CW + 1 > FW) ? CW + 1 : FW;
	localparam int PW  = MA + MB;
	localparam int CHW = $clog2(NCH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_HP, ST_LP, ST_SQ, ST_MAG, ST_M2, ST_P1, ST_P2, ST_RMS, ST_OUT
	} state_t;

	state_t           state_q;
	logic [CHW-1:0]   ch_q;
	logic             grp_q;
	logic             launched_q;
	logic             out_valid_q;

	logic [CW-1:0]        hp_coef_q, lp_coef_q, rms_coef_q;
	logic signed [SW-1:0] off_q [NCH];
	logic signed [SW-1:0] in_q [NCH];

	logic signed [XW-1:0] prev_q [NCH];
	logic signed [FW-1:0] hp_q [NCH];
	logic signed [FW-1:0] lp_q [NCH];
	logic [MSW-1:0]       ms_q [2];

	logic [SUM_W-1:0]     sum_q;
	logic signed [PW-1:0] tmp_q;
	logic [MSW-1:0]       m2_q;
	logic [OUT_W-1:0]     mag_q [2];
	logic [OUT_W-1:0]     rms_q [2];
	logic [OUT_W-1:0]     res_am_q, res_gm_q, res_ar_q, res_gr_q;

	function automatic logic signed [FW-1:0] sat_fw(input logic signed [PW-1:0] v);
		logic hi_one;
		logic hi_zero;
		hi_one  = &v[PW-1:FW-1];
		hi_zero = ~|v[PW-1:FW-1];
		if (hi_one || hi_zero) begin
			return v[FW-1:0];
		end else if (v[PW-1]) begin
			return {1'b1, {(FW-1){1'b0}}};
		end else begin
			return {1'b0, {(FW-1){1'b1}}};
		end
	endfunction

	// datapath of the current channel
	logic signed [XW-1:0] x;
	logic signed [DW-1:0] dx;
	logic signed [VW-1:0] v;
	logic [FW-1:0]        abs_l;
	logic [CW:0]          one_minus_c;

	assign x  = XW'(in_q[ch_q]) - XW'(off_q[ch_q]);
	assign dx = DW'(x) - DW'(prev_q[ch_q]);
	assign v  = VW'(hp_q[ch_q]) + (VW'(dx) <<< FRAC);
	assign abs_l = lp_q[ch_q][FW-1] ? (~lp_q[ch_q] + 1'b1) : lp_q[ch_q];
	assign one_minus_c = (CW+1)'(1 << CW) - (CW+1)'(rms_coef_q);

	mul_ctl_t             mul_ctl;
	logic signed [MA-1:0] mul_a;
	logic [MB-1:0]        mul_b;
	logic signed [PW-1:0] mul_prod;
	logic                 mul_done;
	logic                 sqrt_start;
	logic [SUM_W-1:0]     sqrt_n;
	logic [SUM_W/2-1:0]   sqrt_root;
	logic                 sqrt_done;

	always_comb begin
		mul_ctl.start = 1'b0;
		mul_ctl.nbits = CNT_W'(CW);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_HP: begin
				mul_ctl.start = !launched_q;
				mul_a = MA'(v);
				mul_b = MB'(hp_coef_q) << (MB - CW);
			end
			ST_LP: begin
				mul_ctl.start = !launched_q;
				mul_a = MA'(hp_q[ch_q]) - MA'(lp_q[ch_q]);
				mul_b = MB'(lp_coef_q) << (MB - CW);
			end
			ST_SQ: begin
				mul_ctl.start = !launched_q;
				mul_ctl.nbits = CNT_W'(FW);
				mul_a = MA'({1'b0, abs_l});
				mul_b = MB'(abs_l) << (MB - FW);
			end
			ST_M2: begin
				mul_ctl.start = !launched_q;
				mul_ctl.nbits = CNT_W'(OUT_W);
				mul_a = MA'({1'b0, mag_q[grp_q]});
				mul_b = MB'(mag_q[grp_q]) << (MB - OUT_W);
			end
			ST_P1: begin
				mul_ctl.start = !launched_q;
				mul_ctl.nbits = CNT_W'(CW + 1);
				mul_a = MA'({1'b0, ms_q[grp_q]});
				mul_b = MB'(one_minus_c) << (MB - CW - 1);
			end
			ST_P2: begin
				mul_ctl.start = !launched_q;
				mul_a = MA'({1'b0, m2_q});
				mul_b = MB'(rms_coef_q) << (MB - CW);
			end
			default: begin
			end
		endcase
	end

	assign sqrt_start = !launched_q && (state_q == ST_MAG || state_q == ST_RMS);
	assign sqrt_n = (state_q == ST_RMS) ? SUM_W'(ms_q[grp_q]) : sum_q;

	bvrm_mul #(.MA(MA), .MB(MB)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	bvrm_sqrt #(.W(SUM_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (sqrt_n),
		.root   (sqrt_root),
		.done   (sqrt_done)
	);

	logic signed [PW-1:0] lp_sum;
	logic [OUT_W-1:0]     mag_sat;
	logic [PW-1:0]        ms_sum;

	assign lp_sum  = PW'(lp_q[ch_q]) + (mul_prod >>> CW);
	assign mag_sat = (|sqrt_root[SUM_W/2-1:OUT_W+FRAC]) ? {OUT_W{1'b1}}
		: sqrt_root[OUT_W+FRAC-1:FRAC];
	assign ms_sum  = PW'(tmp_q + mul_prod) >> CW;

	assign samples.ready = (state_q == ST_IDLE);
	assign results.valid = out_valid_q;
	assign results.accel_magnitude = res_am_q;
	assign results.gyro_magnitude  = res_gm_q;
	assign results.accel_rms       = res_ar_q;
	assign results.gyro_rms        = res_gr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			grp_q       <= 1'b0;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			hp_coef_q   <= CW'(HP_COEF_RST);
			lp_coef_q   <= CW'(LP_COEF_RST);
			rms_coef_q  <= CW'(RMS_COEF_RST);
			for (int i = 0; i < NCH; i++) begin
				off_q[i]  <= '0;
				prev_q[i] <= '0;
				hp_q[i]   <= '0;
				lp_q[i]   <= '0;
			end
			ms_q[0] <= '0;
			ms_q[1] <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_HP_COEF:  hp_coef_q  <= wr_data[CW-1:0];
					REG_LP_COEF:  lp_coef_q  <= wr_data[CW-1:0];
					REG_RMS_COEF: rms_coef_q <= wr_data[CW-1:0];
					REG_OFF_AX:   off_q[0]   <= wr_data[SW-1:0];
					REG_OFF_AY:   off_q[1]   <= wr_data[SW-1:0];
					REG_OFF_AZ:   off_q[2]   <= wr_data[SW-1:0];
					REG_OFF_GY:   off_q[3]   <= wr_data[SW-1:0];
					REG_OFF_GZ:   off_q[4]   <= wr_data[SW-1:0];
					default: begin
					end
				endcase
			end

			// park a new beat when the output register is free, else drop the taken one
			if (state_q == ST_OUT && (!out_valid_q || results.ready)) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_ctl.start || sqrt_start) begin
				launched_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						ch_q    <= '0;
						grp_q   <= 1'b0;
						state_q <= ST_HP;
					end
				end
				ST_HP: begin
					if (mul_done) begin
						launched_q   <= 1'b0;
						hp_q[ch_q]   <= sat_fw(mul_prod >>> CW);
						prev_q[ch_q] <= x;
						state_q      <= ST_LP;
					end
				end
				ST_LP: begin
					if (mul_done) begin
						launched_q <= 1'b0;
						lp_q[ch_q] <= sat_fw(lp_sum);
						state_q    <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mul_done) begin
						launched_q <= 1'b0;
						// close the group after the last accel or gyro axis
						if (ch_q == CHW'(2) || ch_q == CHW'(NCH - 1)) begin
							state_q <= ST_MAG;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_HP;
						end
					end
				end
				ST_MAG: begin
					if (sqrt_done) begin
						launched_q <= 1'b0;
						state_q    <= ST_M2;
					end
				end
				ST_M2: begin
					if (mul_done) begin
						launched_q <= 1'b0;
						state_q    <= ST_P1;
					end
				end
				ST_P1: begin
					if (mul_done) begin
						launched_q <= 1'b0;
						state_q    <= ST_P2;
					end
				end
				ST_P2: begin
					if (mul_done) begin
						launched_q   <= 1'b0;
						ms_q[grp_q]  <= ms_sum[MSW-1:0];
						state_q      <= ST_RMS;
					end
				end
				ST_RMS: begin
					if (sqrt_done) begin
						launched_q <= 1'b0;
						if (!grp_q) begin
							grp_q   <= 1'b1;
							ch_q    <= CHW'(3);
							state_q <= ST_HP;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || results.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			in_q[0] <= samples.accel_x;
			in_q[1] <= samples.accel_y;
			in_q[2] <= samples.accel_z;
			in_q[3] <= samples.gyro_y;
			in_q[4] <= samples.gyro_z;
			sum_q   <= '0;
		end
		if (state_q == ST_SQ && mul_done) begin
			sum_q <= sum_q + mul_prod[SUM_W-1:0];
		end
		if (state_q == ST_MAG && sqrt_done) begin
			mag_q[grp_q] <= mag_sat;
		end
		if (state_q == ST_M2 && mul_done) begin
			m2_q <= mul_prod[MSW-1:0];
		end
		if (state_q == ST_P1 && mul_done) begin
			tmp_q <= mul_prod;
		end
		if (state_q == ST_RMS && sqrt_done) begin
			rms_q[grp_q] <= sqrt_root[OUT_W-1:0];
			sum_q        <= '0;
		end
		if (state_q == ST_OUT && (!out_valid_q || results.ready)) begin
			res_am_q <= mag_q[0];
			res_gm_q <= mag_q[1];
			res_ar_q <= rms_q[0];
			res_gr_q <= rms_q[1];
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> (state_q == ST_HP && ch_q == '0 && !grp_q))
		else $error("accepted beat did not start the first axis");

	a_mul_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q != ST_IDLE && state_q != ST_OUT && state_q != ST_MAG
			&& state_q != ST_RMS))
		else $error("multiplier finished outside a multiply step");

	a_sqrt_done_step: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == ST_MAG || state_q == ST_RMS))
		else $error("root unit finished outside a root step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> out_valid_q)
		else $error("pending result dropped");

endmodule

`default_nettype wire

FILE: sim/bvrm_meter_checker.sv
// ----------------------------------------------------------------------------
// bvrm_meter_checker: result predictor and scoreboard
// Watches register writes and both channels, keeps its own copy of the
// filter and mean-square state, works out each result from the accepted
// sample set and compares it field by field with what the block gives.
// ----------------------------------------------------------------------------
`default_nettype none

module bvrm_meter_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	bvrm_in_if        samples,
	bvrm_out_if       results,
	input  wire logic wr_en,
	input  wire logic [bvrm_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [15:0] wr_data,
	output int        fail_count,
	output int        pending_count
);
	import bvrm_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] accel_mag;
		logic [OUT_W-1:0] gyro_mag;
		logic [OUT_W-1:0] accel_rms;
		logic [OUT_W-1:0] gyro_rms;
	} meter_result_t;

	localparam longint SAT_HI  = 64'sd2147483647;
	localparam longint SAT_LO  = -64'sd2147483648;
	localparam logic [63:0] MAG_MAX = 64'd262143;

	logic [15:0] hp_coef, lp_coef, rms_coef;
	longint      axis_offset [NCH];
	longint      prev_x [NCH];
	longint      hp_val [NCH];
	longint      lp_val [NCH];
	logic [63:0] accel_ms, gyro_ms;
	meter_result_t expected_results [$];

	function automatic longint sat32(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 64'd0;
		b = 64'h4000_0000_0000_0000;
		while (b > n)
			b = b >> 2;
		while (b != 64'd0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] smooth_ms(input logic [63:0] ms, input logic [63:0] mag);
		logic [63:0] c;
		c = {48'd0, rms_coef};
		return (ms * (64'd65536 - c) + mag * mag * c) >> 16;
	endfunction

	// advance all five filters by one sample set and form the expected beat
	task automatic filter_sample_set(output meter_result_t res);
		longint          raw [NCH];
		longint          x, d, h, l;
		logic [63:0]     al, sum_a, sum_g, am, gm, ar, gr;
		raw[0] = longint'(samples.accel_x);
		raw[1] = longint'(samples.accel_y);
		raw[2] = longint'(samples.accel_z);
		raw[3] = longint'(samples.gyro_y);
		raw[4] = longint'(samples.gyro_z);
		sum_a = 64'd0;
		sum_g = 64'd0;
		for (int i = 0; i < NCH; i++) begin
			x = raw[i] - axis_offset[i];
			d = (x - prev_x[i]) * 256;
			h = sat32(((hp_val[i] + d) * longint'(hp_coef)) >>> 16);
			hp_val[i] = h;
			prev_x[i] = x;
			l = sat32(lp_val[i] + (((h - lp_val[i]) * longint'(lp_coef)) >>> 16));
			lp_val[i] = l;
			al = (l < 0) ? 64'(-l) : 64'(l);
			if (i < 3)
				sum_a = sum_a + al * al;
			else
				sum_g = sum_g + al * al;
		end
		am = floor_root(sum_a) >> FRAC;
		gm = floor_root(sum_g) >> FRAC;
		if (am > MAG_MAX)
			am = MAG_MAX;
		if (gm > MAG_MAX)
			gm = MAG_MAX;
		accel_ms = smooth_ms(accel_ms, am);
		gyro_ms  = smooth_ms(gyro_ms, gm);
		ar = floor_root(accel_ms);
		gr = floor_root(gyro_ms);
		res.accel_mag = am[OUT_W-1:0];
		res.gyro_mag  = gm[OUT_W-1:0];
		res.accel_rms = ar[OUT_W-1:0];
		res.gyro_rms  = gr[OUT_W-1:0];
	endtask

	assign pending_count = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		meter_result_t exp_r;
		meter_result_t got_r;
		if (!arst_n) begin
			hp_coef  <= 16'(HP_COEF_RST);
			lp_coef  <= 16'(LP_COEF_RST);
			rms_coef <= 16'(RMS_COEF_RST);
			for (int i = 0; i < NCH; i++) begin
				axis_offset[i] = 0;
				prev_x[i] = 0;
				hp_val[i] = 0;
				lp_val[i] = 0;
			end
			accel_ms = 64'd0;
			gyro_ms  = 64'd0;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_HP_COEF:  hp_coef  <= wr_data;
					REG_LP_COEF:  lp_coef  <= wr_data;
					REG_RMS_COEF: rms_coef <= wr_data;
					REG_OFF_AX:   axis_offset[0] = longint'(signed'(wr_data));
					REG_OFF_AY:   axis_offset[1] = longint'(signed'(wr_data));
					REG_OFF_AZ:   axis_offset[2] = longint'(signed'(wr_data));
					REG_OFF_GY:   axis_offset[3] = longint'(signed'(wr_data));
					REG_OFF_GZ:   axis_offset[4] = longint'(signed'(wr_data));
					default: ;
				endcase
			end
			if (samples.valid && samples.ready) begin
				filter_sample_set(exp_r);
				expected_results.push_back(exp_r);
			end
			if (results.valid && results.ready) begin
				got_r = {results.accel_magnitude, results.gyro_magnitude,
					results.accel_rms, results.gyro_rms};
				if (expected_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result beat %h", got_r);
				end else begin
					exp_r = expected_results.pop_front();
					if (got_r !== exp_r) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch exp/got: am %0d/%0d gm %0d/%0d ar %0d/%0d gr %0d/%0d",
								exp_r.accel_mag, got_r.accel_mag, exp_r.gyro_mag, got_r.gyro_mag,
								exp_r.accel_rms, got_r.accel_rms, exp_r.gyro_rms, got_r.gyro_rms);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sim/bandpass_vibration_rms_meter_tb.sv
// ----------------------------------------------------------------------------
// bandpass_vibration_rms_meter_tb: stimulus and verdict
// Drives directed extreme sample sets, then random sample sets across
// several register settings with random gaps and output stalls; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bandpass_vibration_rms_meter_tb;
	import bvrm_pkg::*;

	localparam int CYCLE_LIMIT  = 4000000;
	localparam int PHASES       = 8;
	localparam int SETS_PER_PHASE = 203;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [15:0] wr_data;
	int          fail_count;
	int          pending_count;
	int          cycle_count;
	int          sets_sent;
	bit          calm;

	bvrm_in_if  samples ();
	bvrm_out_if results ();

	bandpass_vibration_rms_meter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	bvrm_meter_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (samples),
		.results       (results),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (calm)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// result side: stall a random number of cycles per beat
	initial begin
		int n;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = draw_gap();
			if (n > 0) begin
				results.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
		end
	end

	task automatic send_set(input logic [15:0] ax, ay, az, gy, gz);
		int n;
		n = draw_gap();
		if (n > 0) begin
			samples.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		samples.valid   <= 1'b1;
		samples.accel_x <= ax;
		samples.accel_y <= ay;
		samples.accel_z <= az;
		samples.gyro_y  <= gy;
		samples.gyro_z  <= gz;
		do @(posedge clk); while (!samples.ready);
		sets_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] hp, lp, rms, input logic [15:0] off [NCH]);
		samples.valid <= 1'b0;
		// let the checker log the last accepted beat before draining
		@(posedge clk);
		wait (pending_count == 0);
		@(posedge clk);
		write_reg(REG_HP_COEF, hp);
		write_reg(REG_LP_COEF, lp);
		write_reg(REG_RMS_COEF, rms);
		write_reg(REG_OFF_AX, off[0]);
		write_reg(REG_OFF_AY, off[1]);
		write_reg(REG_OFF_AZ, off[2]);
		write_reg(REG_OFF_GY, off[3]);
		write_reg(REG_OFF_GZ, off[4]);
		wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] random_axis(input int style);
		case (style)
			0, 1, 2: return 16'($urandom());
			3:       return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
			4:       return 16'($urandom_range(0, 127)) - 16'd64;
			default: return 16'($urandom_range(0, 4095)) - 16'd2048;
		endcase
	endfunction

	initial begin
		logic [15:0] off [NCH];
		logic [15:0] hp, lp, rms;
		logic [15:0] v;
		int style;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		samples.valid = 1'b0;
		samples.accel_x = '0;
		samples.accel_y = '0;
		samples.accel_z = '0;
		samples.gyro_y = '0;
		samples.gyro_z = '0;
		cycle_count = 0;
		sets_sent = 0;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets at reset settings: zero, extremes, alternating steps
		send_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_set(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		for (int k = 0; k < 8; k++) begin
			v = k[0] ? 16'h8000 : 16'h7fff;
			send_set(v, v, v, v, v);
		end
		send_set(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
		send_set(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		send_set(16'h7fff, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
		send_set(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff);
		send_set(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000);
		send_set(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff);

		for (int ph = 0; ph < PHASES; ph++) begin
			for (int i = 0; i < NCH; i++)
				off[i] = 16'd0;
			hp = 16'(HP_COEF_RST);
			lp = 16'(LP_COEF_RST);
			rms = 16'(RMS_COEF_RST);
			case (ph)
				1: begin
					hp = 16'hffff; lp = 16'hffff; rms = 16'hffff;
					for (int i = 0; i < NCH; i++)
						off[i] = 16'h7fff;
				end
				2: begin
					hp = 16'h0000; lp = 16'h0000; rms = 16'h0000;
					for (int i = 0; i < NCH; i++)
						off[i] = 16'h8000;
				end
				3, 5: begin
					hp = 16'($urandom()); lp = 16'($urandom()); rms = 16'($urandom());
					for (int i = 0; i < NCH; i++)
						off[i] = 16'($urandom());
				end
				4: begin
					hp = 16'hffff; lp = 16'hffff; rms = 16'h0001;
					for (int i = 0; i < NCH; i++)
						off[i] = 16'h8000;
				end
				6: begin
					hp = 16'hfff0; lp = 16'h0100; rms = 16'h8000;
					for (int i = 0; i < NCH; i++)
						off[i] = 16'($urandom_range(0, 511)) - 16'd256;
				end
				default: ;
			endcase
			program_regs(hp, lp, rms, off);
			for (int n = 0; n < SETS_PER_PHASE; n++) begin
				// alternate stretches of back-to-back traffic with gappy traffic
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				style = $urandom_range(0, 5);
				send_set(random_axis(style), random_axis(style), random_axis(style),
					random_axis(style), random_axis(style));
			end
		end
		samples.valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (700) @(posedge clk);

		$display("covered %0d sample sets over %0d register settings, extremes included",
			sets_sent, PHASES + 1);
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d failing result beats", fail_count);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
